>>> design/aes128_block_encrypt_macros.svh
// Assertion macros used by the port-level checker
`ifndef AES128_BLOCK_ENCRYPT_MACROS_SVH
`define AES128_BLOCK_ENCRYPT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication with the consequent checked in the following cycle
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> design/aes_pkg.sv
// Package: AES types, S-box and byte helpers
package aes_pkg;
    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_ENCRYPT = 1'b1;

    typedef logic [7:0] t_byte;
    typedef logic [127:0] t_block;

    function automatic t_byte sbox(input t_byte x);
        t_byte v;
        v = 8'h00;
        case (x)
            8'h00: v = 8'h63; 8'h01: v = 8'h7C; 8'h02: v = 8'h77; 8'h03: v = 8'h7B;
            8'h04: v = 8'hF2; 8'h05: v = 8'h6B; 8'h06: v = 8'h6F; 8'h07: v = 8'hC5;
            8'h08: v = 8'h30; 8'h09: v = 8'h01; 8'h0A: v = 8'h67; 8'h0B: v = 8'h2B;
            8'h0C: v = 8'hFE; 8'h0D: v = 8'hD7; 8'h0E: v = 8'hAB; 8'h0F: v = 8'h76;
            8'h10: v = 8'hCA; 8'h11: v = 8'h82; 8'h12: v = 8'hC9; 8'h13: v = 8'h7D;
            8'h14: v = 8'hFA; 8'h15: v = 8'h59; 8'h16: v = 8'h47; 8'h17: v = 8'hF0;
            8'h18: v = 8'hAD; 8'h19: v = 8'hD4; 8'h1A: v = 8'hA2; 8'h1B: v = 8'hAF;
            8'h1C: v = 8'h9C; 8'h1D: v = 8'hA4; 8'h1E: v = 8'h72; 8'h1F: v = 8'hC0;
            8'h20: v = 8'hB7; 8'h21: v = 8'hFD; 8'h22: v = 8'h93; 8'h23: v = 8'h26;
            8'h24: v = 8'h36; 8'h25: v = 8'h3F; 8'h26: v = 8'hF7; 8'h27: v = 8'hCC;
            8'h28: v = 8'h34; 8'h29: v = 8'hA5; 8'h2A: v = 8'hE5; 8'h2B: v = 8'hF1;
            8'h2C: v = 8'h71; 8'h2D: v = 8'hD8; 8'h2E: v = 8'h31; 8'h2F: v = 8'h15;
            8'h30: v = 8'h04; 8'h31: v = 8'hC7; 8'h32: v = 8'h23; 8'h33: v = 8'hC3;
            8'h34: v = 8'h18; 8'h35: v = 8'h96; 8'h36: v = 8'h05; 8'h37: v = 8'h9A;
            8'h38: v = 8'h07; 8'h39: v = 8'h12; 8'h3A: v = 8'h80; 8'h3B: v = 8'hE2;
            8'h3C: v = 8'hEB; 8'h3D: v = 8'h27; 8'h3E: v = 8'hB2; 8'h3F: v = 8'h75;
            8'h40: v = 8'h09; 8'h41: v = 8'h83; 8'h42: v = 8'h2C; 8'h43: v = 8'h1A;
            8'h44: v = 8'h1B; 8'h45: v = 8'h6E; 8'h46: v = 8'h5A; 8'h47: v = 8'hA0;
            8'h48: v = 8'h52; 8'h49: v = 8'h3B; 8'h4A: v = 8'hD6; 8'h4B: v = 8'hB3;
            8'h4C: v = 8'h29; 8'h4D: v = 8'hE3; 8'h4E: v = 8'h2F; 8'h4F: v = 8'h84;
            8'h50: v = 8'h53; 8'h51: v = 8'hD1; 8'h52: v = 8'h00; 8'h53: v = 8'hED;
            8'h54: v = 8'h20; 8'h55: v = 8'hFC; 8'h56: v = 8'hB1; 8'h57: v = 8'h5B;
            8'h58: v = 8'h6A; 8'h59: v = 8'hCB; 8'h5A: v = 8'hBE; 8'h5B: v = 8'h39;
            8'h5C: v = 8'h4A; 8'h5D: v = 8'h4C; 8'h5E: v = 8'h58; 8'h5F: v = 8'hCF;
            8'h60: v = 8'hD0; 8'h61: v = 8'hEF; 8'h62: v = 8'hAA; 8'h63: v = 8'hFB;
            8'h64: v = 8'h43; 8'h65: v = 8'h4D; 8'h66: v = 8'h33; 8'h67: v = 8'h85;
            8'h68: v = 8'h45; 8'h69: v = 8'hF9; 8'h6A: v = 8'h02; 8'h6B: v = 8'h7F;
            8'h6C: v = 8'h50; 8'h6D: v = 8'h3C; 8'h6E: v = 8'h9F; 8'h6F: v = 8'hA8;
            8'h70: v = 8'h51; 8'h71: v = 8'hA3; 8'h72: v = 8'h40; 8'h73: v = 8'h8F;
            8'h74: v = 8'h92; 8'h75: v = 8'h9D; 8'h76: v = 8'h38; 8'h77: v = 8'hF5;
            8'h78: v = 8'hBC; 8'h79: v = 8'hB6; 8'h7A: v = 8'hDA; 8'h7B: v = 8'h21;
            8'h7C: v = 8'h10; 8'h7D: v = 8'hFF; 8'h7E: v = 8'hF3; 8'h7F: v = 8'hD2;
            8'h80: v = 8'hCD; 8'h81: v = 8'h0C; 8'h82: v = 8'h13; 8'h83: v = 8'hEC;
            8'h84: v = 8'h5F; 8'h85: v = 8'h97; 8'h86: v = 8'h44; 8'h87: v = 8'h17;
            8'h88: v = 8'hC4; 8'h89: v = 8'hA7; 8'h8A: v = 8'h7E; 8'h8B: v = 8'h3D;
            8'h8C: v = 8'h64; 8'h8D: v = 8'h5D; 8'h8E: v = 8'h19; 8'h8F: v = 8'h73;
            8'h90: v = 8'h60; 8'h91: v = 8'h81; 8'h92: v = 8'h4F; 8'h93: v = 8'hDC;
            8'h94: v = 8'h22; 8'h95: v = 8'h2A; 8'h96: v = 8'h90; 8'h97: v = 8'h88;
            8'h98: v = 8'h46; 8'h99: v = 8'hEE; 8'h9A: v = 8'hB8; 8'h9B: v = 8'h14;
            8'h9C: v = 8'hDE; 8'h9D: v = 8'h5E; 8'h9E: v = 8'h0B; 8'h9F: v = 8'hDB;
            8'hA0: v = 8'hE0; 8'hA1: v = 8'h32; 8'hA2: v = 8'h3A; 8'hA3: v = 8'h0A;
            8'hA4: v = 8'h49; 8'hA5: v = 8'h06; 8'hA6: v = 8'h24; 8'hA7: v = 8'h5C;
            8'hA8: v = 8'hC2; 8'hA9: v = 8'hD3; 8'hAA: v = 8'hAC; 8'hAB: v = 8'h62;
            8'hAC: v = 8'h91; 8'hAD: v = 8'h95; 8'hAE: v = 8'hE4; 8'hAF: v = 8'h79;
            8'hB0: v = 8'hE7; 8'hB1: v = 8'hC8; 8'hB2: v = 8'h37; 8'hB3: v = 8'h6D;
            8'hB4: v = 8'h8D; 8'hB5: v = 8'hD5; 8'hB6: v = 8'h4E; 8'hB7: v = 8'hA9;
            8'hB8: v = 8'h6C; 8'hB9: v = 8'h56; 8'hBA: v = 8'hF4; 8'hBB: v = 8'hEA;
            8'hBC: v = 8'h65; 8'hBD: v = 8'h7A; 8'hBE: v = 8'hAE; 8'hBF: v = 8'h08;
            8'hC0: v = 8'hBA; 8'hC1: v = 8'h78; 8'hC2: v = 8'h25; 8'hC3: v = 8'h2E;
            8'hC4: v = 8'h1C; 8'hC5: v = 8'hA6; 8'hC6: v = 8'hB4; 8'hC7: v = 8'hC6;
            8'hC8: v = 8'hE8; 8'hC9: v = 8'hDD; 8'hCA: v = 8'h74; 8'hCB: v = 8'h1F;
            8'hCC: v = 8'h4B; 8'hCD: v = 8'hBD; 8'hCE: v = 8'h8B; 8'hCF: v = 8'h8A;
            8'hD0: v = 8'h70; 8'hD1: v = 8'h3E; 8'hD2: v = 8'hB5; 8'hD3: v = 8'h66;
            8'hD4: v = 8'h48; 8'hD5: v = 8'h03; 8'hD6: v = 8'hF6; 8'hD7: v = 8'h0E;
            8'hD8: v = 8'h61; 8'hD9: v = 8'h35; 8'hDA: v = 8'h57; 8'hDB: v = 8'hB9;
            8'hDC: v = 8'h86; 8'hDD: v = 8'hC1; 8'hDE: v = 8'h1D; 8'hDF: v = 8'h9E;
            8'hE0: v = 8'hE1; 8'hE1: v = 8'hF8; 8'hE2: v = 8'h98; 8'hE3: v = 8'h11;
            8'hE4: v = 8'h69; 8'hE5: v = 8'hD9; 8'hE6: v = 8'h8E; 8'hE7: v = 8'h94;
            8'hE8: v = 8'h9B; 8'hE9: v = 8'h1E; 8'hEA: v = 8'h87; 8'hEB: v = 8'hE9;
            8'hEC: v = 8'hCE; 8'hED: v = 8'h55; 8'hEE: v = 8'h28; 8'hEF: v = 8'hDF;
            8'hF0: v = 8'h8C; 8'hF1: v = 8'hA1; 8'hF2: v = 8'h89; 8'hF3: v = 8'h0D;
            8'hF4: v = 8'hBF; 8'hF5: v = 8'hE6; 8'hF6: v = 8'h42; 8'hF7: v = 8'h68;
            8'hF8: v = 8'h41; 8'hF9: v = 8'h99; 8'hFA: v = 8'h2D; 8'hFB: v = 8'h0F;
            8'hFC: v = 8'hB0; 8'hFD: v = 8'h54; 8'hFE: v = 8'hBB; 8'hFF: v = 8'h16;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // multiply by x in GF(2^8)
    function automatic t_byte xtime(input t_byte x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1B : 8'h00);
    endfunction

    // byte n of a block, byte 0 in the top bits
    function automatic t_byte get_byte(input t_block b, input int n);
        return b[127 - 8*n -: 8];
    endfunction
endpackage

>>> design/aes_ram.sv
// Generic single-port-write RAM with registered read
module aes_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 22
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

>>> design/aes_col_lane.sv
// One column lane: SubBytes on a shifted column, optional MixColumns
module aes_col_lane (
    input  logic [31:0] i_col,
    input  logic        i_mix,
    output logic [31:0] o_col
);
    import aes_pkg::*;

    t_byte a0, a1, a2, a3;
    t_byte m0, m1, m2, m3;

    always_comb begin
        a0 = sbox(i_col[31:24]);
        a1 = sbox(i_col[23:16]);
        a2 = sbox(i_col[15:8]);
        a3 = sbox(i_col[7:0]);
        m0 = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
        m1 = xtime(a1) ^ xtime(a2) ^ a2 ^ a3 ^ a0;
        m2 = xtime(a2) ^ xtime(a3) ^ a3 ^ a0 ^ a1;
        m3 = xtime(a3) ^ xtime(a0) ^ a0 ^ a1 ^ a2;
        o_col = i_mix ? {m0, m1, m2, m3} : {a0, a1, a2, a3};
    end
endmodule

>>> design/aes128_block_encrypt.sv
// AES-128 encryption core: round key store, four column lanes, round sequencer.
// Input channel: i_valid/o_stall with i_command, i_key_slot, i_block_hi/lo.
//   command 0 loads round key key_slot (0..10, others ignored) and produces
//   no result. command 1 encrypts one 128-bit block.
// Output channel: o_valid/i_stall with o_cipher_hi/lo.
// Each round has two phases. The registered key read for a round is issued
// in phase 0, and the round is applied in phase 1.
// Round-key-0 addition plus ten rounds run before o_valid is raised, and the
// result transfer can come in the same cycle that o_valid rises.
// The core takes no new block until the result has been taken and it is back
// in idle: the rounds, then the result transfer, then the return to idle.
// An output stall holds the result and so delays the next block.
// o_stall is high while a block is in flight or a result is unread; a
// stalled result holds until taken. Load transfers are taken at any time
// the core is not busy.
// Reset (synchronous, active low) empties the pipeline; the key store is
// not cleared and must be loaded before an encrypt.
module aes128_block_encrypt #(
    parameter int NUM_ROUND_KEYS = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [3:0]  i_key_slot,
    input  logic [63:0] i_block_hi,
    input  logic [63:0] i_block_lo,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_cipher_hi,
    output logic [63:0] o_cipher_lo
);
    import aes_pkg::*;

    localparam int RW = $clog2(NUM_ROUND_KEYS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]   r_state, n_state;
    // phase 0 waits for the key read, phase 1 applies a round
    logic         r_phase;
    logic [RW-1:0] r_round;
    t_block       r_s;
    logic [63:0]  rdata;
    logic [63:0]  rdata_lo;
    logic         in_xfer, we;
    t_block       shifted, lanes_out, rk;
    logic         mix;

    assign in_xfer = i_valid && !o_stall;
    assign we = in_xfer && (i_command == CMD_LOAD)
                && ({28'd0, i_key_slot} < NUM_ROUND_KEYS);

    // two writes per load would need two ports, so store halves in two RAMs
    aes_ram #(.WIDTH(64), .DEPTH(NUM_ROUND_KEYS)) u_ram_hi (
        .i_clk(i_clk), .i_we(we), .i_waddr(i_key_slot[RW-1:0]),
        .i_wdata(i_block_hi), .i_raddr(r_round), .o_rdata(rdata)
    );
    aes_ram #(.WIDTH(64), .DEPTH(NUM_ROUND_KEYS)) u_ram_lo (
        .i_clk(i_clk), .i_we(we), .i_waddr(i_key_slot[RW-1:0]),
        .i_wdata(i_block_lo), .i_raddr(r_round), .o_rdata(rdata_lo)
    );

    assign rk = {rdata, rdata_lo};
    assign mix = (r_round != RW'(NUM_ROUND_KEYS - 1));

    // ShiftRows: out byte r+4c takes in byte r+4(c+r)
    always_comb begin
        shifted = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                shifted[127 - 8*(4*c + r) -: 8] = get_byte(r_s, (4*(c + r) + r) & 15);
            end
        end
    end

    for (genvar g = 0; g < 4; g++) begin : g_lane
        aes_col_lane u_lane (
            .i_col(shifted[127 - 32*g -: 32]),
            .i_mix(mix),
            .o_col(lanes_out[127 - 32*g -: 32])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (in_xfer && i_command == CMD_ENCRYPT) n_state = ST_RUN;
            ST_RUN:  if (r_phase && r_round == RW'(NUM_ROUND_KEYS - 1)) n_state = ST_OUT;
            ST_OUT:  if (!i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= 1'b0;
            r_round <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_phase <= 1'b0;
                    r_round <= '0;
                end
                ST_RUN: begin
                    // phase 0: key for r_round read in flight; phase 1: apply
                    r_phase <= !r_phase;
                    if (r_phase) r_round <= r_round + RW'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && in_xfer) begin
            r_s <= {i_block_hi, i_block_lo};
        end else if (r_state == ST_RUN && r_phase) begin
            r_s <= (r_round == '0) ? (r_s ^ rk) : (lanes_out ^ rk);
        end
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign o_cipher_hi = r_s[127:64];
    assign o_cipher_lo = r_s[63:0];
endmodule

>>> design/aes_checker.sv
// Port-level checker for the encryption core, bound to the top level
`include "aes128_block_encrypt_macros.svh"
module aes_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        i_command,
    input logic        o_valid,
    input logic        i_stall,
    input logic [63:0] o_cipher_hi,
    input logic [63:0] o_cipher_lo
);
    // a result never appears without the core being busy
    `AES_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_valid, o_stall)
    // a stalled result holds its data
    `AES_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_cipher_hi) && $stable(o_cipher_lo))
    // a load transfer never makes the core busy
    `AES_ASSERT_NEXT(a_load_free, i_clk, i_rst_n,
        i_valid && !o_stall && !i_command, !o_stall)
    // an encrypt transfer makes the core busy, with no result yet
    `AES_ASSERT_NEXT(a_enc_busy, i_clk, i_rst_n,
        i_valid && !o_stall && i_command, o_stall && !o_valid)
endmodule

bind aes128_block_encrypt aes_checker u_aes_checker (.*);

>>> test/aes128_block_encrypt_checker.sv
// Scoreboard for the AES-128 core: tracks the round keys and checks each ciphertext
`timescale 1ns / 1ps
module aes128_block_encrypt_checker
    import aes_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic        i_command,
    input  logic [3:0]  i_key_slot,
    input  logic [63:0] i_block_hi,
    input  logic [63:0] i_block_lo,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [63:0] i_cipher_hi,
    input  logic [63:0] i_cipher_lo,
    output int          o_errors,
    output int          o_pending
);
    localparam int KEY_COUNT = 11;

    logic [7:0]   sub_lut [256];
    logic [127:0] key_mirror [KEY_COUNT];
    logic [127:0] cipher_q [$];
    int           error_count = 0;

    assign o_errors  = error_count;
    assign o_pending = cipher_q.size();

    function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        p = 8'h00;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= a;
            a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1B : 8'h00);
        end
        return p;
    endfunction

    // S-box from the field inverse (x^254) and the affine map
    initial begin
        logic [7:0] inv, sq;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h01;
            sq  = x[7:0];
            for (int e = 0; e < 8; e++) begin
                if (e != 0) inv = gmul(inv, sq);
                sq = gmul(sq, sq);
            end
            if (x == 0) inv = 8'h00;
            sub_lut[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                       ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
    end

    function automatic logic [127:0] encrypt_block(input logic [127:0] plain);
        logic [7:0] st [16];
        logic [7:0] tmp [16];
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] res;
        for (int n = 0; n < 16; n++)
            st[n] = plain[127-8*n -: 8] ^ key_mirror[0][127-8*n -: 8];
        for (int rnd = 1; rnd < KEY_COUNT; rnd++) begin
            for (int c = 0; c < 4; c++)
                for (int r = 0; r < 4; r++)
                    tmp[4*c+r] = sub_lut[st[(4*(c+r)+r) & 15]];
            st = tmp;
            if (rnd != KEY_COUNT - 1) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
                    st[4*c]   = gmul(a0, 8'h02) ^ gmul(a1, 8'h03) ^ a2 ^ a3;
                    st[4*c+1] = a0 ^ gmul(a1, 8'h02) ^ gmul(a2, 8'h03) ^ a3;
                    st[4*c+2] = a0 ^ a1 ^ gmul(a2, 8'h02) ^ gmul(a3, 8'h03);
                    st[4*c+3] = gmul(a0, 8'h03) ^ a1 ^ a2 ^ gmul(a3, 8'h02);
                end
            end
            for (int n = 0; n < 16; n++)
                st[n] ^= key_mirror[rnd][127-8*n -: 8];
        end
        for (int n = 0; n < 16; n++)
            res[127-8*n -: 8] = st[n];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] mismatch %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        logic [127:0] want;
        if (i_rst_n) begin
            if (i_valid && !i_stall_in) begin
                if (i_command == CMD_LOAD) begin
                    if (i_key_slot < KEY_COUNT)
                        key_mirror[i_key_slot] = {i_block_hi, i_block_lo};
                end else begin
                    cipher_q.push_back(encrypt_block({i_block_hi, i_block_lo}));
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (cipher_q.size() == 0) begin
                    $display("[%0t] ciphertext with no block outstanding", $realtime);
                    error_count++;
                end else begin
                    want = cipher_q.pop_front();
                    if (i_cipher_hi !== want[127:64])
                        report_mismatch("cipher_hi", i_cipher_hi, want[127:64]);
                    if (i_cipher_lo !== want[63:0])
                        report_mismatch("cipher_lo", i_cipher_lo, want[63:0]);
                end
            end
        end
    end
endmodule

>>> test/aes128_block_encrypt_tb.sv
// Testbench top: drives key loads and encrypt blocks into the AES-128 core
`timescale 1ns / 1ps
module aes128_block_encrypt_tb;
    import aes_pkg::*;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic        i_command = CMD_LOAD;
    logic [3:0]  i_key_slot = 4'd0;
    logic [63:0] i_block_hi = '0;
    logic [63:0] i_block_lo = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_cipher_hi;
    logic [63:0] o_cipher_lo;
    int          errors;
    int          pending;
    bit          no_idle = 1'b0;
    int          quiet_cycles = 0;

    localparam int WATCHDOG_LIMIT = 5000;

    aes128_block_encrypt dut (.*);

    aes128_block_encrypt_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall_in(o_stall), .i_command(i_command),
        .i_key_slot(i_key_slot), .i_block_hi(i_block_hi), .i_block_lo(i_block_lo),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_cipher_hi(o_cipher_hi), .i_cipher_lo(o_cipher_lo),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 31);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send(input logic cmd, input logic [3:0] slot,
                        input logic [63:0] hi, input logic [63:0] lo);
        while (!no_idle && $urandom_range(0, 99) < 31) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_command  <= cmd;
        i_key_slot <= slot;
        i_block_hi <= hi;
        i_block_lo <= lo;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand64();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // every round key loaded before the first encrypt
        for (int k = 0; k < 11; k++)
            send(CMD_LOAD, k[3:0], {$urandom, $urandom}, {$urandom, $urandom});
        send(CMD_ENCRYPT, 4'd0, '0, '0);
        send(CMD_ENCRYPT, 4'd15, '1, '1);
        send(CMD_ENCRYPT, 4'd0, 64'h0011223344556677, 64'h8899AABBCCDDEEFF);
        // slots past the last key are dropped
        for (int k = 11; k < 16; k++)
            send(CMD_LOAD, k[3:0], '1, '1);
        send(CMD_LOAD, 4'd0, '0, '0);
        send(CMD_LOAD, 4'd10, '1, '1);
        send(CMD_ENCRYPT, 4'd7, '0, '1);
        send(CMD_ENCRYPT, 4'd0, '1, '0);

        // drain before the random part
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);

        for (int n = 0; n < 2000; n++) begin
            no_idle = (n >= 800 && n < 1100);
            if ($urandom_range(0, 99) < 15)
                send(CMD_LOAD, 4'($urandom_range(0, 15)), rand64(), rand64());
            else
                send(CMD_ENCRYPT, 4'($urandom_range(0, 15)), rand64(), rand64());
        end
        no_idle = 1'b0;
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule

>>> files.f
+incdir+design
design/aes_pkg.sv
design/aes_ram.sv
design/aes_col_lane.sv
design/aes128_block_encrypt.sv
design/aes_checker.sv
test/aes128_block_encrypt_checker.sv
test/aes128_block_encrypt_tb.sv
